// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the heading unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define CHU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/chu_pkg.sv -----
// Types, constants and the arctangent table of the compass heading unit.
package chu_pkg;

  localparam int unsigned XY_W       = 36;  // scaled axis with CORDIC growth
  localparam int unsigned ANGLE_W    = 31;  // angle in 2^-16 tenth-degree units
  localparam int unsigned ENTRY_W    = 26;
  localparam int unsigned STEP_IDX_W = 5;
  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned HEADING_W  = 12;

  localparam logic signed [ANGLE_W-1:0] HALF_TURN = 31'sd117964800;  // 1800 * 2^16
  localparam logic [HEADING_W-1:0] HEAD_EAST  = 12'd1800;
  localparam logic [HEADING_W-1:0] HEAD_WEST  = 12'd3600;
  localparam logic [HEADING_W-1:0] HEAD_NORTH = 12'd2700;
  localparam logic [HEADING_W-1:0] HEAD_SOUTH = 12'd900;
  localparam logic [HEADING_W-1:0] HEAD_MIN   = 12'd0;
  localparam logic [HEADING_W-1:0] HEAD_MAX   = 12'd3600;

  typedef struct packed {
    logic [7:0] mag_x_high;
    logic [7:0] mag_x_low;
    logic [7:0] mag_z_high;
    logic [7:0] mag_z_low;
    logic [7:0] mag_y_high;
    logic [7:0] mag_y_low;
    logic [7:0] acc_x_low;
    logic [7:0] acc_x_high;
    logic [7:0] acc_y_low;
    logic [7:0] acc_y_high;
    logic [7:0] acc_z_low;
    logic [7:0] acc_z_high;
  } sample_t;

  typedef struct packed {
    logic signed [15:0]    field_x;
    logic signed [15:0]    field_y;
    logic signed [15:0]    field_z;
    logic [HEADING_W-1:0]  heading;
    logic [HEADING_W-1:0]  previous_heading;
    logic signed [15:0]    accel_x;
    logic signed [15:0]    accel_y;
    logic signed [15:0]    accel_z;
  } result_t;

  // Status of the CORDIC core toward the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } core_status_t;

  // atan(2^-i) in 2^-16 tenth-degree units, rounded to nearest.
  function automatic logic [ENTRY_W-1:0] angle_entry(input logic [STEP_IDX_W-1:0] idx);
    logic [ENTRY_W-1:0] e;
    unique case (idx)
      5'd0:    e = 26'd29491200;
      5'd1:    e = 26'd17409672;
      5'd2:    e = 26'd9198793;
      5'd3:    e = 26'd4669451;
      5'd4:    e = 26'd2343786;
      5'd5:    e = 26'd1173036;
      5'd6:    e = 26'd586661;
      5'd7:    e = 26'd293348;
      5'd8:    e = 26'd146676;
      5'd9:    e = 26'd73339;
      5'd10:   e = 26'd36669;
      5'd11:   e = 26'd18335;
      5'd12:   e = 26'd9167;
      5'd13:   e = 26'd4584;
      5'd14:   e = 26'd2292;
      5'd15:   e = 26'd1146;
      5'd16:   e = 26'd573;
      5'd17:   e = 26'd286;
      5'd18:   e = 26'd143;
      5'd19:   e = 26'd72;
      5'd20:   e = 26'd36;
      5'd21:   e = 26'd18;
      5'd22:   e = 26'd9;
      5'd23:   e = 26'd4;
      default: e = 26'd0;
    endcase
    return e;
  endfunction

endpackage

// ----- hw/rtl/chu_cordic.sv -----
// Iterative CORDIC vectoring core that turns magnetometer X and Y into a heading.
`include "assert_macros.svh"

module chu_cordic #(
  parameter int unsigned NUM_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [15:0]            x_i,
  input  logic signed [15:0]            y_i,
  input  logic                          ack_i,
  output chu_pkg::core_status_t         status_o,
  output logic [chu_pkg::HEADING_W-1:0] heading_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam logic [chu_pkg::STEP_IDX_W-1:0] LastStep =
    chu_pkg::STEP_IDX_W'(NUM_STEPS - 1);

  state_e state_q, state_d;
  logic [chu_pkg::STEP_IDX_W-1:0] cnt_q, cnt_d;
  logic signed [chu_pkg::XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [chu_pkg::ANGLE_W-1:0] ang_q, ang_d;
  logic axis_q, axis_d;
  logic [chu_pkg::HEADING_W-1:0] axis_head_q, axis_head_d;

  logic signed [chu_pkg::XY_W-1:0] x_ext, y_ext, dx, dy;
  logic signed [chu_pkg::ANGLE_W-1:0] step_ang, sum;
  logic y_pos;
  logic [13:0] sum_hi;
  logic [chu_pkg::HEADING_W-1:0] final_head;

  // Scale the input axes by 2^16 with sign extension.
  assign x_ext = {{(chu_pkg::XY_W-32){x_i[15]}}, x_i, 16'h0000};
  assign y_ext = {{(chu_pkg::XY_W-32){y_i[15]}}, y_i, 16'h0000};

  // Shared rotation unit: shifted terms and the table angle of this step.
  assign dx       = y_q >>> cnt_q;
  assign dy       = x_q >>> cnt_q;
  assign step_ang = {{(chu_pkg::ANGLE_W-chu_pkg::ENTRY_W){1'b0}},
                     chu_pkg::angle_entry(cnt_q)};
  assign y_pos    = !y_q[chu_pkg::XY_W-1] && (y_q != '0);

  // Offset the angle, clamp below zero and above the full turn.
  assign sum    = ang_q + chu_pkg::HALF_TURN;
  assign sum_hi = sum[29:16];
  always_comb begin
    if (sum[chu_pkg::ANGLE_W-1]) begin
      final_head = chu_pkg::HEAD_MIN;
    end else if (sum_hi > 14'(chu_pkg::HEAD_MAX)) begin
      final_head = chu_pkg::HEAD_MAX;
    end else begin
      final_head = sum_hi[chu_pkg::HEADING_W-1:0];
    end
  end

  assign heading_o     = axis_q ? axis_head_q : final_head;
  assign status_o.idle = (state_q == ST_IDLE);
  assign status_o.done = (state_q == ST_DONE);

  // Sequence: set up on start, rotate once per cycle, hold the result until taken.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    y_d         = y_q;
    ang_d       = ang_q;
    axis_d      = axis_q;
    axis_head_d = axis_head_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          if (y_i == '0) begin
            axis_d      = 1'b1;
            axis_head_d = x_i[15] ? chu_pkg::HEAD_WEST : chu_pkg::HEAD_EAST;
            state_d     = ST_DONE;
          end else if (x_i == '0) begin
            axis_d      = 1'b1;
            axis_head_d = y_i[15] ? chu_pkg::HEAD_SOUTH : chu_pkg::HEAD_NORTH;
            state_d     = ST_DONE;
          end else begin
            axis_d  = 1'b0;
            state_d = ST_RUN;
            if (x_i[15]) begin
              // Fold the left half plane over and start at a half turn.
              x_d   = -x_ext;
              y_d   = -y_ext;
              ang_d = y_i[15] ? -chu_pkg::HALF_TURN : chu_pkg::HALF_TURN;
            end else begin
              x_d   = x_ext;
              y_d   = y_ext;
              ang_d = '0;
            end
          end
        end
      end
      ST_RUN: begin
        if (y_pos) begin
          x_d   = x_q + dx;
          y_d   = y_q - dy;
          ang_d = ang_q + step_ang;
        end else begin
          x_d   = x_q - dx;
          y_d   = y_q + dy;
          ang_d = ang_q - step_ang;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    ang_q       <= ang_d;
    axis_q      <= axis_d;
    axis_head_q <= axis_head_d;
  end

  `CHU_ASSERT(start_when_idle, !start_i || (state_q == ST_IDLE),
              "start while the core is busy")
  `CHU_ASSERT_NEXT(last_step_ends, (state_q == ST_RUN) && (cnt_q == LastStep),
                   state_q == ST_DONE, "rotation did not end after the last step")
  `CHU_ASSERT_NEXT(done_holds, (state_q == ST_DONE) && !ack_i,
                   (state_q == ST_DONE) && $stable(heading_o),
                   "result changed before it was taken")

endmodule

// ----- hw/rtl/compass_heading_unit.sv -----
// Top level of the compass heading unit: sample capture, CORDIC core and result register.
//
// Input channel in_valid_i / in_ready_o carries one sensor sample: magnetometer bytes
// X, Z, Y (each axis high byte first) and accelerometer bytes X, Y, Z (low byte first).
// Output channel out_valid_o / out_ready_i carries the signed axes, the heading in
// tenths of a degree (0..3600, 1800 for a vector along +X) and the previous heading.
// An item is taken on a clock edge with valid and ready both high.
// The core runs CORDIC_STEPS rotations from accept to result valid (capped at 24 steps),
// none when a magnetometer axis is zero; one CORDIC rotation runs per cycle in a
// single shared add/shift unit, so a new sample is taken only once the core is idle again.
// in_ready_o is high while the core is idle; a sample may be taken while the last
// result still waits in the output register.
// If the receiver stalls, the finished heading waits inside the core and the input
// stays closed until the output register frees up.
// Reset clears the previous heading to zero and empties the output register.
`include "assert_macros.svh"

module compass_heading_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  chu_pkg::sample_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output chu_pkg::result_t  out_data_o
);

  localparam int unsigned NumSteps =
    (CORDIC_STEPS > chu_pkg::TABLE_LEN) ? chu_pkg::TABLE_LEN : CORDIC_STEPS;

  chu_pkg::sample_t in_q;
  chu_pkg::result_t out_q;
  logic out_valid_q;
  logic [chu_pkg::HEADING_W-1:0] last_heading_q;

  chu_pkg::core_status_t core_status;
  logic [chu_pkg::HEADING_W-1:0] core_heading;
  logic accept, ack, load;
  logic signed [15:0] mag_x, mag_y;

  assign accept = in_valid_i && in_ready_o;
  assign ack    = !out_valid_q || out_ready_i;
  assign load   = core_status.done && ack;

  assign mag_x = {in_data_i.mag_x_high, in_data_i.mag_x_low};
  assign mag_y = {in_data_i.mag_y_high, in_data_i.mag_y_low};

  assign in_ready_o  = core_status.idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  chu_cordic #(
    .NUM_STEPS (NumSteps)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .x_i       (mag_x),
    .y_i       (mag_y),
    .ack_i     (ack),
    .status_o  (core_status),
    .heading_o (core_heading)
  );

  // Hold the sample for the axis fields of its result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // Assemble the result when the core finishes and the output slot is free.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.field_x          <= {in_q.mag_x_high, in_q.mag_x_low};
      out_q.field_y          <= {in_q.mag_y_high, in_q.mag_y_low};
      out_q.field_z          <= {in_q.mag_z_high, in_q.mag_z_low};
      out_q.heading          <= core_heading;
      out_q.previous_heading <= last_heading_q;
      out_q.accel_x          <= {in_q.acc_x_high, in_q.acc_x_low};
      out_q.accel_y          <= {in_q.acc_y_high, in_q.acc_y_low};
      out_q.accel_z          <= {in_q.acc_z_high, in_q.acc_z_low};
    end
  end

  // Track the output item and the heading of the last sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      last_heading_q <= '0;
    end else begin
      if (load) begin
        out_valid_q    <= 1'b1;
        last_heading_q <= core_heading;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `CHU_ASSERT_NEXT(busy_after_accept, accept, !in_ready_o,
                   "input still open after a sample was taken")
  `CHU_ASSERT_NEXT(prev_tracks_load, load,
                   out_valid_o && (last_heading_q == out_data_o.heading),
                   "previous heading not updated with the delivered heading")

endmodule
